// ----- hdl/pwbr_pkg.sv -----
// shared types, constants and helpers for the pulse-width bit receiver
package pwbr_pkg;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_LOW    = 2'd1,
        PH_WAIT_SAMPLE = 2'd2,
        PH_WAIT_HIGH   = 2'd3
    } t_phase;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SAMPLE_DELAY  = 2'd0;
    localparam t_cfg_idx REG_TIMEOUT_TICKS = 2'd1;
    localparam t_cfg_idx REG_EXPECTED_BITS = 2'd2;

    // register widths and reset values
    localparam int unsigned DELAY_W  = 8;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned CFG_W    = 10;
    localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RST  = 8'd32;
    localparam logic [DELAY_W-1:0] TIMEOUT_TICKS_RST = 8'h3f;
    localparam logic [COUNT_W-1:0] EXPECTED_BITS_RST = 10'd264;

    // result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       timed_out;
    } t_result;

    // move a partial byte's bits to the top, low bits zero
    function automatic logic [7:0] pad_byte(input logic [7:0] b, input logic [2:0] bib);
        logic [3:0] sh;
        sh = 4'd8 - {1'b0, bib};
        if (bib == 3'd0) begin
            return b;
        end
        return 8'(b << sh);
    endfunction

endpackage

// ----- hdl/pulse_width_bit_receiver_packer.sv -----
// pulse-width bit receiver and byte packer, top level
// a result goes to the output register, or to the skid register on a stall
// throughput: one input beat per cycle, every cycle, while the output drains
// an output register plus a skid register decouple the two channels
// reset (synchronous, active low): idle, counters and shift byte cleared,
// registers back to delay 32, timeout 63, 264 bits
module pulse_width_bit_receiver_packer #(
    parameter int unsigned MAX_BITS   = 512,
    parameter int unsigned TICK_WIDTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [pwbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pwbr_pkg::CFG_W-1:0]      i_cfg_data,
    // line sample / arm beats
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic                            i_line_level,
    // received bytes
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_data_byte,
    output logic                            o_last,
    output logic                            o_timed_out
);

    localparam int unsigned BL_W = $clog2(MAX_BITS + 1);

    // configuration registers
    logic [pwbr_pkg::DELAY_W-1:0] r_sample_delay;
    logic [pwbr_pkg::DELAY_W-1:0] r_timeout_ticks;
    logic [pwbr_pkg::COUNT_W-1:0] r_expected_bits;

    // receiver state
    pwbr_pkg::t_phase      r_phase, n_phase;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [BL_W-1:0]       r_bits_left, n_bits_left;
    logic [7:0]            r_shift, n_shift;
    logic [2:0]            r_bib, n_bib;

    // output register and skid
    logic                 r_out_valid;
    pwbr_pkg::t_result    r_out;
    logic                 r_skid_valid;
    pwbr_pkg::t_result    r_skid;

    logic                 accept;
    logic                 res_fire;
    pwbr_pkg::t_result    res;

    logic [TICK_WIDTH-1:0] delay_load, timeout_load, tick_dec;
    logic                  tick_done;
    logic [7:0]            shift_new;
    logic [2:0]            bib_new;
    logic [BL_W-1:0]       bits_dec, arm_bits;

    // skid free means a result always has somewhere to go
    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;

    // counter loads taken modulo the counter width, zero acts as full wrap
    assign delay_load   = TICK_WIDTH'(r_sample_delay);
    assign timeout_load = TICK_WIDTH'(r_timeout_ticks);
    assign tick_dec     = r_tick - 1'b1;
    assign tick_done    = (tick_dec == '0);

    assign shift_new = {r_shift[6:0], i_line_level};
    assign bib_new   = r_bib + 3'd1;
    assign bits_dec  = r_bits_left - 1'b1;

    // bit count clamped to 1..MAX_BITS at arm time
    always_comb begin
        if (r_expected_bits == '0) begin
            arm_bits = BL_W'(1);
        end else if (32'(r_expected_bits) > MAX_BITS) begin
            arm_bits = BL_W'(MAX_BITS);
        end else begin
            arm_bits = BL_W'(r_expected_bits);
        end
    end

    // next state and result of one beat
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_bib       = r_bib;
        res_fire    = 1'b0;
        res         = '0;

        if (i_command) begin
            // arm, drops any reply in progress
            n_bits_left = arm_bits;
            n_shift     = '0;
            n_bib       = '0;
            n_tick      = timeout_load;
            n_phase     = pwbr_pkg::PH_WAIT_LOW;
        end else begin
            case (r_phase)
                pwbr_pkg::PH_WAIT_LOW: begin
                    if (!i_line_level) begin
                        n_tick  = delay_load;
                        n_phase = pwbr_pkg::PH_WAIT_SAMPLE;
                    end else begin
                        n_tick = tick_dec;
                        if (tick_done) begin
                            res_fire      = 1'b1;
                            res.data_byte = pwbr_pkg::pad_byte(r_shift, r_bib);
                            res.last      = 1'b1;
                            res.timed_out = 1'b1;
                            n_phase       = pwbr_pkg::PH_IDLE;
                            n_tick        = '0;
                            n_bits_left   = '0;
                            n_shift       = '0;
                            n_bib         = '0;
                        end
                    end
                end
                pwbr_pkg::PH_WAIT_SAMPLE: begin
                    n_tick = tick_dec;
                    if (tick_done) begin
                        n_bits_left = bits_dec;
                        if (bits_dec == '0) begin
                            // final bit of the reply
                            res_fire      = 1'b1;
                            res.data_byte = pwbr_pkg::pad_byte(shift_new, bib_new);
                            res.last      = 1'b1;
                            n_phase       = pwbr_pkg::PH_IDLE;
                            n_tick        = '0;
                            n_shift       = '0;
                            n_bib         = '0;
                        end else begin
                            n_tick  = timeout_load;
                            n_phase = pwbr_pkg::PH_WAIT_HIGH;
                            n_bib   = bib_new;
                            n_shift = shift_new;
                            if (bib_new == 3'd0) begin
                                // byte complete
                                res_fire      = 1'b1;
                                res.data_byte = shift_new;
                                n_shift       = '0;
                            end
                        end
                    end
                end
                pwbr_pkg::PH_WAIT_HIGH: begin
                    if (i_line_level) begin
                        n_tick  = timeout_load;
                        n_phase = pwbr_pkg::PH_WAIT_LOW;
                    end else begin
                        n_tick = tick_dec;
                        if (tick_done) begin
                            res_fire      = 1'b1;
                            res.data_byte = pwbr_pkg::pad_byte(r_shift, r_bib);
                            res.last      = 1'b1;
                            res.timed_out = 1'b1;
                            n_phase       = pwbr_pkg::PH_IDLE;
                            n_tick        = '0;
                            n_bits_left   = '0;
                            n_shift       = '0;
                            n_bib         = '0;
                        end
                    end
                end
                default: begin
                    // idle ticks are ignored
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_delay  <= pwbr_pkg::SAMPLE_DELAY_RST;
            r_timeout_ticks <= pwbr_pkg::TIMEOUT_TICKS_RST;
            r_expected_bits <= pwbr_pkg::EXPECTED_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwbr_pkg::REG_SAMPLE_DELAY:  r_sample_delay  <= i_cfg_data[7:0];
                pwbr_pkg::REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[7:0];
                pwbr_pkg::REG_EXPECTED_BITS: r_expected_bits <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // receiver state, advances on accepted beats only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pwbr_pkg::PH_IDLE;
            r_tick      <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_bib       <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_bib       <= n_bib;
        end
    end

    // output register with skid: a stalled output parks the new result aside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (accept && res_fire) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= accept && res_fire;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (accept && res_fire) begin
                r_skid <= res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept && res_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out.data_byte;
    assign o_last      = r_out.last;
    assign o_timed_out = r_out.timed_out;

endmodule
